FILE: rtl/core/kae_pkg.sv
package kae_pkg;

    // Scan layout
    localparam int unsigned SCAN_W     = 64;
    localparam int unsigned GROUP_W    = 8;
    localparam int unsigned ARROW_GRP  = 7;
    localparam int unsigned NUM_ARROWS = 4;

    // Counter widths
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned PHASE_W = 8;
    localparam int unsigned CFG_W   = 8;

    // Result packing: held, pressed, released, arrow_fire, zero pad to bytes
    localparam int unsigned FIRE_W   = NUM_ARROWS;
    localparam int unsigned RES_BITS = 3 * SCAN_W + FIRE_W;
    localparam int unsigned M_DATA_W = ((RES_BITS + 7) / 8) * 8;
    localparam int unsigned PAD_W    = M_DATA_W - RES_BITS;

    // Register indexes on the write port
    localparam logic REG_INITIAL_DELAY = 1'b0;
    localparam logic REG_REPEAT_PERIOD = 1'b1;

    localparam logic [CFG_W-1:0] INITIAL_DELAY_RST = 8'd15;
    localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = 8'd4;

    // Position of each arrow within the arrow group, in arrow_fire order
    // (up, down, left, right)
    typedef logic [2:0] arrow_pos_t;
    localparam arrow_pos_t ARROW_BIT [NUM_ARROWS] = '{3'd3, 3'd0, 3'd1, 3'd2};

    // Per-arrow step control from the top level
    typedef struct packed {
        logic step;
        logic now_down;
        logic prev_down;
    } arrow_ctl_t;

endpackage

FILE: rtl/core/kae_arrow_repeat.sv
module kae_arrow_repeat (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  kae_pkg::arrow_ctl_t              ctl,
    input  logic [kae_pkg::CFG_W-1:0]        initial_delay,
    input  logic [kae_pkg::CFG_W-1:0]        repeat_period,
    output logic                             fire
);

    logic                          held_reg, held_next;
    logic [kae_pkg::HOLD_W-1:0]    hold_reg, hold_next;
    logic [kae_pkg::PHASE_W-1:0]   phase_reg, phase_next;

    logic [kae_pkg::HOLD_W-1:0]    hold_inc;
    logic [kae_pkg::PHASE_W:0]     phase_inc;
    logic                          below_delay;
    logic                          phase_wrap;

    assign hold_inc    = hold_reg + kae_pkg::HOLD_W'(1);
    assign below_delay = hold_inc < kae_pkg::HOLD_W'(initial_delay);
    assign phase_inc   = {1'b0, phase_reg} + (kae_pkg::PHASE_W + 1)'(1);
    // period 0 behaves as 1: any increment reaches it
    assign phase_wrap  = phase_inc >= {1'b0, repeat_period};

    // Next state and fire for one frame
    always_comb begin
        held_next  = held_reg;
        hold_next  = hold_reg;
        phase_next = phase_reg;
        fire       = 1'b0;
        if (ctl.step) begin
            priority if (!ctl.now_down) begin
                held_next  = 1'b0;
                hold_next  = '0;
                phase_next = '0;
            end else if (!ctl.prev_down) begin
                // press frame always fires
                held_next  = 1'b1;
                hold_next  = '0;
                phase_next = '0;
                fire       = 1'b1;
            end else if (!held_reg) begin
                held_next  = 1'b1;
                hold_next  = '0;
                phase_next = '0;
            end else if (below_delay) begin
                hold_next  = hold_inc;
                phase_next = '0;
            end else begin
                hold_next  = hold_inc;
                fire       = (phase_reg == '0);
                phase_next = phase_wrap ? '0 : phase_inc[kae_pkg::PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= 1'b0;
            hold_reg  <= '0;
            phase_reg <= '0;
        end else begin
            held_reg  <= held_next;
            hold_reg  <= hold_next;
            phase_reg <= phase_next;
        end
    end

endmodule

FILE: rtl/core/keypad_edge_and_autorepeat_core.sv
// Keypad edge detector with auto-repeat for the four arrow keys. Each input
// item is one 64-bit key scan (group g in bits 8g+7..8g, 1 = down); each
// scan yields exactly one result item with the held, newly pressed and newly
// released masks plus arrow repeat events (bit0 up, bit1 down, bit2 left,
// bit3 right; arrows sit in scan bits 59, 56, 57, 58). An arrow fires on its
// press frame, then after initial_delay held frames, then every
// repeat_period frames; release clears it. One item is accepted per cycle
// unless the output stalls, via the input register, then the result
// register; a stalled result register holds, and the input register then
// takes the next scan only if empty. Write initial_delay (index 0) and
// repeat_period (index 1) only while no item is in flight.
module keypad_edge_and_autorepeat_core (
    input  logic                              aclk,
    input  logic                              aresetn,

    // scan input: tdata = scan_bits[63:0]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [kae_pkg::SCAN_W-1:0]        s_tdata,

    // result: tdata = held_keys[63:0], pressed_keys[127:64],
    //   released_keys[191:128], arrow_fire[195:192], zero pad [199:196]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [kae_pkg::M_DATA_W-1:0]      m_tdata,

    // configuration write port
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [kae_pkg::CFG_W-1:0]         cfg_wdata
);

    logic [kae_pkg::CFG_W-1:0]    delay_reg, delay_next;
    logic [kae_pkg::CFG_W-1:0]    period_reg, period_next;

    logic                         in_valid_reg, in_valid_next;
    logic [kae_pkg::SCAN_W-1:0]   in_scan_reg, in_scan_next;
    logic [kae_pkg::SCAN_W-1:0]   prev_scan_reg, prev_scan_next;

    logic                         out_valid_reg, out_valid_next;
    logic [kae_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;

    logic                         advance;
    logic                         step;
    logic [kae_pkg::GROUP_W-1:0]  cur_grp;
    logic [kae_pkg::GROUP_W-1:0]  prev_grp;
    logic [kae_pkg::FIRE_W-1:0]   fire;
    kae_pkg::arrow_ctl_t          arrow_ctl [kae_pkg::NUM_ARROWS];

    // Pipeline control
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration registers
    always_comb begin
        delay_next  = delay_reg;
        period_next = period_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                kae_pkg::REG_INITIAL_DELAY: delay_next  = cfg_wdata;
                kae_pkg::REG_REPEAT_PERIOD: period_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // Arrow group of this and the previous frame
    assign cur_grp  = in_scan_reg[kae_pkg::ARROW_GRP*kae_pkg::GROUP_W +: kae_pkg::GROUP_W];
    assign prev_grp = prev_scan_reg[kae_pkg::ARROW_GRP*kae_pkg::GROUP_W +: kae_pkg::GROUP_W];

    // One repeat unit per arrow
    for (genvar k = 0; k < kae_pkg::NUM_ARROWS; k++) begin : g_arrow
        assign arrow_ctl[k].step      = step;
        assign arrow_ctl[k].now_down  = cur_grp[kae_pkg::ARROW_BIT[k]];
        assign arrow_ctl[k].prev_down = prev_grp[kae_pkg::ARROW_BIT[k]];

        kae_arrow_repeat u_arrow (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctl           (arrow_ctl[k]),
            .initial_delay (delay_reg),
            .repeat_period (period_reg),
            .fire          (fire[k])
        );
    end

    // Input register and previous scan
    always_comb begin
        in_valid_next  = in_valid_reg;
        in_scan_next   = in_scan_reg;
        prev_scan_next = prev_scan_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            if (s_tvalid) begin
                in_scan_next = s_tdata;
            end
        end
        if (step) begin
            prev_scan_next = in_scan_reg;
        end
    end

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
        if (step) begin
            out_data_next = {{kae_pkg::PAD_W{1'b0}},
                             fire,
                             ~in_scan_reg & prev_scan_reg,
                             in_scan_reg & ~prev_scan_reg,
                             in_scan_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg     <= kae_pkg::INITIAL_DELAY_RST;
            period_reg    <= kae_pkg::REPEAT_PERIOD_RST;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_scan_reg <= '0;
        end else begin
            delay_reg     <= delay_next;
            period_reg    <= period_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            prev_scan_reg <= prev_scan_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        in_scan_reg  <= in_scan_next;
        out_data_reg <= out_data_next;
    end

endmodule

FILE: rtl/core/kae_checker.sv
module kae_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [kae_pkg::M_DATA_W-1:0]      m_tdata
);

    logic [kae_pkg::SCAN_W-1:0] held;
    logic [kae_pkg::SCAN_W-1:0] pressed;
    logic [kae_pkg::SCAN_W-1:0] released;
    logic [kae_pkg::FIRE_W-1:0] arrow_fire;
    logic                       up_down;

    assign held       = m_tdata[0 +: kae_pkg::SCAN_W];
    assign pressed    = m_tdata[kae_pkg::SCAN_W +: kae_pkg::SCAN_W];
    assign released   = m_tdata[2*kae_pkg::SCAN_W +: kae_pkg::SCAN_W];
    assign arrow_fire = m_tdata[3*kae_pkg::SCAN_W +: kae_pkg::FIRE_W];
    assign up_down    = held[kae_pkg::ARROW_GRP*kae_pkg::GROUP_W
                             + int'(kae_pkg::ARROW_BIT[0])];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a key cannot be both newly pressed and newly released
    a_edges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pressed & released) == '0)
        else $error("pressed and released overlap");

    // pressed keys are down, released keys are up
    a_masks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pressed & ~held) == '0 && (released & held) == '0)
        else $error("edge mask disagrees with held keys");

    // an up-arrow repeat needs the up arrow down
    a_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && arrow_fire[0] |-> up_down)
        else $error("up repeat without key down");

    // no result without a scan offered or taken before it
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) || $past(s_tvalid, 1))
        else $error("result appeared without a scan");

endmodule

bind keypad_edge_and_autorepeat_core kae_checker u_kae_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

FILE: tb/testbench.sv
module testbench;

    localparam int ARROW_BASE     = int'(kae_pkg::ARROW_GRP * kae_pkg::GROUP_W);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_FRAMES   = 325;

    // One result item, unpacked from m_tdata
    typedef struct packed {
        logic [kae_pkg::FIRE_W-1:0] fire;
        logic [kae_pkg::SCAN_W-1:0] released;
        logic [kae_pkg::SCAN_W-1:0] pressed;
        logic [kae_pkg::SCAN_W-1:0] held;
    } frame_t;

    // Directed stimulus: a scan, or a register write between scans
    typedef enum logic [1:0] {ROW_SCAN, ROW_DELAY, ROW_PERIOD} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [kae_pkg::SCAN_W-1:0] value;
        logic                       pin;
        logic [kae_pkg::FIRE_W-1:0] fire;
    } stim_row_t;

    localparam int NUM_ROWS = 29;
    // pin = 1: the arrow_fire column is the expected value as written
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{ROW_SCAN,   64'h0000_0000_0000_0000, 1'b1, 4'h0},
        '{ROW_SCAN,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'hF},  // all keys newly down
        '{ROW_SCAN,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'h0},
        '{ROW_SCAN,   64'h0000_0000_0000_0000, 1'b1, 4'h0},  // all released
        '{ROW_SCAN,   64'h0800_0000_0000_0000, 1'b1, 4'h1},  // up
        '{ROW_SCAN,   64'h0100_0000_0000_0000, 1'b1, 4'h2},  // down
        '{ROW_SCAN,   64'h0200_0000_0000_0000, 1'b1, 4'h4},  // left
        '{ROW_SCAN,   64'h0400_0000_0000_0000, 1'b1, 4'h8},  // right
        '{ROW_SCAN,   64'h5555_5555_5555_5555, 1'b1, 4'h2},  // right stays held
        '{ROW_SCAN,   64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 4'h5},
        '{ROW_SCAN,   64'h00FF_FFFF_FFFF_FFFF, 1'b1, 4'h0},  // non-arrow keys only
        '{ROW_SCAN,   64'h0000_0000_0000_0000, 1'b1, 4'h0},
        // zero delay and zero period: fire on every held frame
        '{ROW_DELAY,  64'd0,                   1'b0, 4'h0},
        '{ROW_PERIOD, 64'd0,                   1'b0, 4'h0},
        '{ROW_SCAN,   64'h0F00_0000_0000_0000, 1'b1, 4'hF},
        '{ROW_SCAN,   64'h0F00_0000_0000_0000, 1'b1, 4'hF},
        '{ROW_SCAN,   64'h0F00_0000_0000_0000, 1'b1, 4'hF},
        // settings changed while the arrows stay held
        '{ROW_DELAY,  64'd255,                 1'b0, 4'h0},
        '{ROW_PERIOD, 64'd255,                 1'b0, 4'h0},
        '{ROW_SCAN,   64'h0F00_0000_0000_0000, 1'b1, 4'h0},
        '{ROW_SCAN,   64'h0F00_0000_0000_0000, 1'b0, 4'h0},
        '{ROW_DELAY,  64'd2,                   1'b0, 4'h0},
        '{ROW_SCAN,   64'h0F00_0000_0000_0000, 1'b1, 4'hF},
        '{ROW_SCAN,   64'h0F00_0000_0000_0000, 1'b0, 4'h0},
        // period lowered below the running phase
        '{ROW_PERIOD, 64'd1,                   1'b0, 4'h0},
        '{ROW_SCAN,   64'h0F00_0000_0000_0000, 1'b0, 4'h0},
        '{ROW_SCAN,   64'h0F00_0000_0000_0000, 1'b0, 4'h0},
        '{ROW_SCAN,   64'h0000_0000_0000_0000, 1'b1, 4'h0},
        '{ROW_SCAN,   64'hF0FF_FFFF_FFFF_FFFF, 1'b1, 4'h0}
    };

    logic                         aclk;
    logic                         aresetn   = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [kae_pkg::SCAN_W-1:0]   s_tdata   = '0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [kae_pkg::M_DATA_W-1:0] m_tdata;
    logic                         cfg_we    = 1'b0;
    logic                         cfg_index = kae_pkg::REG_INITIAL_DELAY;
    logic [kae_pkg::CFG_W-1:0]    cfg_wdata = '0;

    keypad_edge_and_autorepeat_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Shadow of the block's registers and key state
    logic [kae_pkg::CFG_W-1:0]   delay_reg  = kae_pkg::INITIAL_DELAY_RST;
    logic [kae_pkg::CFG_W-1:0]   period_reg = kae_pkg::REPEAT_PERIOD_RST;
    logic [kae_pkg::SCAN_W-1:0]  last_scan  = '0;
    logic                        arrow_down [kae_pkg::NUM_ARROWS] = '{default: 1'b0};
    logic [kae_pkg::HOLD_W-1:0]  hold_count [kae_pkg::NUM_ARROWS] = '{default: '0};
    logic [kae_pkg::PHASE_W-1:0] rep_phase  [kae_pkg::NUM_ARROWS] = '{default: '0};

    frame_t                     frames_due [$];
    int                         mismatches     = 0;
    int                         quiet_cycles   = 0;
    int                         send_idle_pct  = 0;
    int                         recv_stall_pct = 0;
    logic                       pin_on   = 1'b0;
    logic [kae_pkg::FIRE_W-1:0] pin_fire = '0;

    // Masks and typematic repeat for one scan; advances the shadow state
    function automatic frame_t predict_frame(input logic [kae_pkg::SCAN_W-1:0] scan);
        frame_t     r;
        logic       now_dn;
        logic       was_dn;
        logic [8:0] nxt;
        r.held     = scan;
        r.pressed  = scan & ~last_scan;
        r.released = ~scan & last_scan;
        r.fire     = '0;
        for (int k = 0; k < kae_pkg::NUM_ARROWS; k++) begin
            now_dn = scan[ARROW_BASE + kae_pkg::ARROW_BIT[k]];
            was_dn = last_scan[ARROW_BASE + kae_pkg::ARROW_BIT[k]];
            if (!now_dn || !was_dn || !arrow_down[k]) begin
                // release, fresh press, or a down key without held state
                arrow_down[k] = now_dn;
                hold_count[k] = '0;
                rep_phase[k]  = '0;
                r.fire[k]     = now_dn && !was_dn;
            end else begin
                hold_count[k] = hold_count[k] + 1'b1;
                if (hold_count[k] < {8'd0, delay_reg}) begin
                    rep_phase[k] = '0;
                end else begin
                    r.fire[k]    = (rep_phase[k] == '0);
                    nxt          = {1'b0, rep_phase[k]} + 9'd1;
                    rep_phase[k] = (nxt >= {1'b0, period_reg}) ?
                                   '0 : nxt[kae_pkg::PHASE_W-1:0];
                end
            end
        end
        last_scan = scan;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
    endtask

    // Result channel backpressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Accept monitor: predict on input items, check result items
    always @(posedge aclk) begin : monitor
        frame_t want;
        frame_t got;
        if (aresetn) begin
            quiet_cycles++;
            if (s_tvalid && s_tready) begin
                want = predict_frame(s_tdata);
                if (pin_on)
                    want.fire = pin_fire;
                frames_due.push_back(want);
                quiet_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                quiet_cycles = 0;
                got = m_tdata[kae_pkg::RES_BITS-1:0];
                if (frames_due.size() == 0) begin
                    report_mismatch("unexpected result", got.held, '0);
                end else begin
                    want = frames_due.pop_front();
                    if (got.held !== want.held)
                        report_mismatch("held_keys", got.held, want.held);
                    if (got.pressed !== want.pressed)
                        report_mismatch("pressed_keys", got.pressed, want.pressed);
                    if (got.released !== want.released)
                        report_mismatch("released_keys", got.released, want.released);
                    if (got.fire !== want.fire)
                        report_mismatch("arrow_fire", 64'(got.fire), 64'(want.fire));
                    if (m_tdata[kae_pkg::M_DATA_W-1:kae_pkg::RES_BITS] !== '0)
                        report_mismatch("pad",
                            64'(m_tdata[kae_pkg::M_DATA_W-1:kae_pkg::RES_BITS]), '0);
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Present one scan, with random idle cycles ahead of it
    task automatic send_scan(input logic [kae_pkg::SCAN_W-1:0] scan, input logic pin,
                             input logic [kae_pkg::FIRE_W-1:0] fire);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= scan;
        pin_on   = pin;
        pin_fire = fire;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and wait until every result is out and the pipe is empty
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [kae_pkg::CFG_W-1:0] val);
        settle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == kae_pkg::REG_INITIAL_DELAY)
            delay_reg = val;
        else
            period_reg = val;
    endtask

    task automatic set_traffic(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    initial begin : stimulus
        logic [kae_pkg::SCAN_W-1:0] scan;
        logic [3:0]                 pattern;
        logic                       noisy;
        logic [kae_pkg::CFG_W-1:0]  ph_delay;
        logic [kae_pkg::CFG_W-1:0]  ph_period;
        int                         span;
        int                         sent;
        int                         run_len;

        repeat (7) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed table
        set_traffic(0, 0);
        foreach (DIRECTED_ROWS[i]) begin
            case (DIRECTED_ROWS[i].kind)
                ROW_SCAN: begin
                    send_scan(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].pin,
                              DIRECTED_ROWS[i].fire);
                end
                ROW_DELAY: begin
                    write_reg(kae_pkg::REG_INITIAL_DELAY,
                              DIRECTED_ROWS[i].value[kae_pkg::CFG_W-1:0]);
                end
                default: begin
                    write_reg(kae_pkg::REG_REPEAT_PERIOD,
                              DIRECTED_ROWS[i].value[kae_pkg::CFG_W-1:0]);
                end
            endcase
        end

        // random phases: arrow patterns held for runs, some noisy runs
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin ph_delay = 8'd1;   ph_period = 8'd1;   end
                1: begin ph_delay = 8'd255; ph_period = 8'd255; end
                2: begin ph_delay = 8'd0;   ph_period = 8'd0;   end
                3: begin ph_delay = 8'd15;  ph_period = 8'd4;   end
                4: begin ph_delay = 8'd2;   ph_period = 8'd3;   end
                default: begin
                    ph_delay  = 8'($urandom_range(1, 24));
                    ph_period = 8'($urandom_range(1, 12));
                end
            endcase
            write_reg(kae_pkg::REG_INITIAL_DELAY, ph_delay);
            write_reg(kae_pkg::REG_REPEAT_PERIOD, ph_period);
            case (ph % 4)
                0: set_traffic(0, 0);
                1: set_traffic(87, 0);
                2: set_traffic(0, 87);
                default: set_traffic(19, 19);
            endcase
            sent = 0;
            while (sent < PHASE_FRAMES) begin
                pattern = 4'($urandom_range(15));
                noisy   = ($urandom_range(4) == 0);
                span    = int'(delay_reg) + 3 * int'(period_reg) + 2;
                if (span > 300)
                    span = 300;
                run_len = $urandom_range(1, span);
                for (int i = 0; i < run_len && sent < PHASE_FRAMES; i++) begin
                    scan = {$urandom, $urandom};
                    if (!noisy)
                        scan[ARROW_BASE +: 4] = pattern;
                    send_scan(scan, 1'b0, '0);
                    sent++;
                end
            end
        end

        settle();
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: keypad_edge_and_autorepeat_core.f
rtl/core/kae_pkg.sv
rtl/core/kae_arrow_repeat.sv
rtl/core/keypad_edge_and_autorepeat_core.sv
rtl/core/kae_checker.sv
tb/testbench.sv
